// File: rtl/tclr_pkg.sv
// Shared types and constants for the console line ring.
// Used by tclr_cfg, tclr_ctrl, tclr_dp and text_console_line_ring.
`timescale 1ns / 1ps
package tclr_pkg;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned LINE_W      = 5;
    localparam int unsigned COL_W       = 7;
    localparam int unsigned Y_W         = 12;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned APB_AW      = 4;
    localparam int unsigned APB_DW      = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_GLYPH = 2'd0;
    localparam logic [1:0] REG_GAP   = 2'd1;
    localparam logic [1:0] REG_TOP   = 2'd2;

    localparam logic [6:0] GLYPH_RST = 7'd14;
    localparam logic [5:0] GAP_RST   = 6'd5;
    localparam logic [7:0] TOP_RST   = 8'd5;

    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHR_LF    = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE = 2'd0,
        KIND_CLS  = 2'd1,
        KIND_DRAW = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef struct packed {
        logic [6:0] glyph_height;
        logic [5:0] line_gap;
        logic [7:0] top_margin;
    } cfg_t;

    typedef struct packed {
        logic  take_item;
        logic  sweep_init;
        logic  sweep_mem;
        logic  sweep_rows;
        logic  put_char;
        logic  back_space;
        logic  line_done;
        logic  ring_reset;
        logic  redraw_init;
        logic  read_issue;
        logic  draw_step;
        logic  emit;
        logic  emit_last;
        kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             is_print;
        logic             is_lf;
        logic             is_bs;
        logic             mem_swept;
        logic             rows_swept;
        logic             need_clear;
        logic             draw_any;
        logic             draw_last;
        logic             out_free;
    } sts_t;

endpackage

// File: rtl/tclr_cfg.sv
// APB register block: glyph height, line gap and top margin.
// Depends on tclr_pkg.
`timescale 1ns / 1ps
module tclr_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tclr_pkg::APB_AW-1:0]   paddr,
    input  logic [tclr_pkg::APB_DW-1:0]   pwdata,
    output logic [tclr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output tclr_pkg::cfg_t                cfg
);
    import tclr_pkg::*;

    logic [6:0] glyph_reg;
    logic [5:0] gap_reg;
    logic [7:0] top_reg;
    logic       wr;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_reg <= GLYPH_RST;
            gap_reg   <= GAP_RST;
            top_reg   <= TOP_RST;
        end else if (wr) begin
            unique case (idx)
                REG_GLYPH: glyph_reg <= pwdata[6:0];
                REG_GAP:   gap_reg   <= pwdata[5:0];
                REG_TOP:   top_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_GLYPH: prdata = {25'd0, glyph_reg};
            REG_GAP:   prdata = {26'd0, gap_reg};
            REG_TOP:   prdata = {24'd0, top_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.glyph_height = glyph_reg;
    assign cfg.line_gap     = gap_reg;
    assign cfg.top_margin   = top_reg;

endmodule

// File: rtl/tclr_ctrl.sv
// Sequencer for the console line ring: decodes each transfer and steps the datapath.
// Depends on tclr_pkg; drives tclr_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module tclr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  tclr_pkg::sts_t sts,
    output tclr_pkg::cmd_t cmd
);
    import tclr_pkg::*;

    typedef enum logic [3:0] {
        S_MEM_CLR,
        S_IDLE,
        S_EXEC,
        S_DONE,
        S_ROW_CLR,
        S_CLS_LAST,
        S_READ,
        S_DRAW_INIT,
        S_DRAW_CLS,
        S_DRAW
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_MEM_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_MEM_CLR: begin
                cmd.sweep_mem = 1'b1;
                if (sts.mem_swept) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.take_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (sts.req)
                    REQ_BYTE: begin
                        priority if (sts.is_print) begin
                            cmd.put_char = 1'b1;
                            state_next   = S_DONE;
                        end else if (sts.is_lf) begin
                            cmd.line_done = 1'b1;
                            state_next    = S_DRAW_INIT;
                        end else if (sts.is_bs) begin
                            cmd.back_space = 1'b1;
                            state_next     = S_DONE;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd.ring_reset = 1'b1;
                        cmd.sweep_init = 1'b1;
                        state_next     = S_ROW_CLR;
                    end
                    REQ_READ: begin
                        cmd.read_issue = 1'b1;
                        state_next     = S_READ;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DONE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ROW_CLR: begin
                cmd.sweep_rows = 1'b1;
                if (sts.rows_swept) state_next = S_CLS_LAST;
            end
            S_CLS_LAST: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_CLS;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_READ;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DRAW_INIT: begin
                cmd.redraw_init = 1'b1;
                state_next      = sts.need_clear ? S_DRAW_CLS : S_DRAW;
            end
            S_DRAW_CLS: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_CLS;
                    state_next    = S_DRAW;
                end
            end
            S_DRAW: begin
                priority if (!sts.draw_any) begin
                    state_next = S_DONE;
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DRAW;
                    cmd.emit_last = sts.draw_last;
                    cmd.draw_step = 1'b1;
                    if (sts.draw_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/tclr_dp.sv
// Datapath of the console line ring: character memory, ring pointers,
// sweep and draw counters, output register. Depends on tclr_pkg.
`timescale 1ns / 1ps
module tclr_dp #(
    parameter int LINES = 25,
    parameter int COLS  = 66
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tclr_pkg::cmd_t                     cmd,
    output tclr_pkg::sts_t                     sts,
    input  tclr_pkg::cfg_t                     cfg,
    input  logic [tclr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [tclr_pkg::REQ_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tclr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [tclr_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast
);
    import tclr_pkg::*;

    localparam int ROW_LEN = COLS + 1;
    localparam int DEPTH   = LINES * ROW_LEN;
    localparam int LW      = $clog2(LINES);
    localparam int CW      = $clog2(ROW_LEN);
    localparam int AW      = $clog2(DEPTH);
    localparam int RW      = $clog2(LINES + 1);

    // latched item
    logic [REQ_W-1:0]  req_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic [LINE_W-1:0] qline_reg;
    logic [COL_W-1:0]  qcol_reg;

    // ring state
    logic [LW-1:0] wl_reg, ol_reg;
    logic [CW-1:0] col_reg;
    logic          empty_reg, seen_reg;

    // sweeps
    logic [AW-1:0] sweep_addr_reg, row_addr_reg;
    logic [LW-1:0] row_cnt_reg;

    // redraw
    logic [LW-1:0]  idx_reg;
    logic [Y_W-1:0] y_reg;
    logic [RW-1:0]  rem_reg;

    // memory
    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] mem_q_reg;
    logic              in_range_reg;

    // output register
    logic              ov_reg, olast_reg;
    kind_t             okind_reg;
    logic [LINE_W-1:0] oline_reg;
    logic [Y_W-1:0]    oy_reg;
    logic [CHAR_W-1:0] ochar_reg;

    logic [LW-1:0]     wl_inc, ol_inc, idx_inc;
    logic              ring_full, col_room, q_in_range, mem_we;
    logic [AW-1:0]     cur_addr, q_addr, waddr;
    logic [CHAR_W-1:0] wdata;
    logic [7:0]        pitch;
    logic [RW-1:0]     rem_init;

    assign wl_inc  = (wl_reg == LW'(LINES - 1)) ? '0 : wl_reg + 1'b1;
    assign ol_inc  = (ol_reg == LW'(LINES - 1)) ? '0 : ol_reg + 1'b1;
    assign idx_inc = (idx_reg == LW'(LINES - 1)) ? '0 : idx_reg + 1'b1;

    assign ring_full  = (wl_reg == ol_reg) && !empty_reg;
    assign col_room   = col_reg < CW'(COLS);
    assign cur_addr   = AW'(wl_reg) * AW'(ROW_LEN) + AW'(col_reg);
    assign q_in_range = ({1'b0, qline_reg} < 6'(LINES)) && ({1'b0, qcol_reg} <= 8'(COLS));
    assign q_addr     = AW'(qline_reg) * AW'(ROW_LEN) + AW'(qcol_reg);
    assign pitch      = {1'b0, cfg.glyph_height} + {2'b00, cfg.line_gap};

    always_comb begin
        if (ring_full) begin
            rem_init = RW'(LINES);
        end else if (wl_reg > ol_reg) begin
            rem_init = RW'(wl_reg) - RW'(ol_reg);
        end else begin
            rem_init = '0;
        end
    end

    assign mem_we = cmd.sweep_mem || cmd.sweep_rows || cmd.put_char || cmd.line_done;
    assign wdata  = (cmd.put_char && col_room) ? byte_reg : '0;

    always_comb begin
        priority if (cmd.sweep_mem) begin
            waddr = sweep_addr_reg;
        end else if (cmd.sweep_rows) begin
            waddr = row_addr_reg;
        end else begin
            waddr = cur_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (cmd.read_issue && q_in_range) mem_q_reg <= mem[q_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            req_reg   <= s_axis_tuser;
            byte_reg  <= s_axis_tdata[7:0];
            qline_reg <= s_axis_tdata[12:8];
            qcol_reg  <= s_axis_tdata[19:13];
        end
        if (cmd.read_issue) in_range_reg <= q_in_range;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg    <= '0;
            ol_reg    <= '0;
            col_reg   <= '0;
            empty_reg <= 1'b1;
            seen_reg  <= 1'b0;
        end else begin
            priority if (cmd.ring_reset) begin
                wl_reg    <= '0;
                ol_reg    <= '0;
                col_reg   <= '0;
                empty_reg <= 1'b1;
                seen_reg  <= 1'b0;
            end else if (cmd.line_done) begin
                col_reg   <= '0;
                if (ring_full) ol_reg <= ol_inc;
                wl_reg    <= wl_inc;
                empty_reg <= 1'b0;
            end else if (cmd.put_char) begin
                if (col_room) col_reg <= col_reg + 1'b1;
            end else if (cmd.back_space) begin
                if (col_reg != '0) col_reg <= col_reg - 1'b1;
            end else if (cmd.redraw_init) begin
                if (ring_full) seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            row_addr_reg   <= '0;
            row_cnt_reg    <= '0;
        end else if (cmd.sweep_init) begin
            sweep_addr_reg <= '0;
            row_addr_reg   <= '0;
            row_cnt_reg    <= '0;
        end else if (cmd.sweep_mem) begin
            sweep_addr_reg <= sts.mem_swept ? '0 : sweep_addr_reg + 1'b1;
        end else if (cmd.sweep_rows) begin
            row_addr_reg <= row_addr_reg + AW'(ROW_LEN);
            row_cnt_reg  <= row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            y_reg   <= '0;
            rem_reg <= '0;
        end else if (cmd.redraw_init) begin
            idx_reg <= ol_reg;
            y_reg   <= {4'd0, cfg.top_margin};
            rem_reg <= rem_init;
        end else if (cmd.draw_step) begin
            idx_reg <= idx_inc;
            y_reg   <= y_reg + {4'd0, pitch};
            rem_reg <= rem_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.emit) begin
            ov_reg <= 1'b1;
        end else if (m_axis_tready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            okind_reg <= cmd.emit_kind;
            olast_reg <= cmd.emit_last;
            oline_reg <= (cmd.emit_kind == KIND_DRAW) ? LINE_W'(idx_reg) : '0;
            oy_reg    <= (cmd.emit_kind == KIND_DRAW) ? y_reg : '0;
            ochar_reg <= (cmd.emit_kind == KIND_READ && in_range_reg) ? mem_q_reg : '0;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {7'd0, ochar_reg, oy_reg, oline_reg};

    assign sts.req        = req_reg;
    assign sts.is_print   = byte_reg >= CHR_SPACE;
    assign sts.is_lf      = byte_reg == CHR_LF;
    assign sts.is_bs      = byte_reg == CHR_BS;
    assign sts.mem_swept  = sweep_addr_reg == AW'(DEPTH - 1);
    assign sts.rows_swept = row_cnt_reg == LW'(LINES - 1);
    assign sts.need_clear = ring_full && seen_reg;
    assign sts.draw_any   = rem_reg != '0;
    assign sts.draw_last  = rem_reg == RW'(1);
    assign sts.out_free   = !ov_reg || m_axis_tready;

endmodule

// File: rtl/text_console_line_ring.sv
// Console line ring for a character display: top level.
// Instantiates tclr_cfg, tclr_ctrl and tclr_dp; depends on tclr_pkg.
//
// Use: console requests enter on the s_axis channel, results leave on m_axis.
// Each request gives one or more result transfers; tlast marks the final one.
// One request is processed at a time; s_axis_tready is high only when idle.
// Results per request:
//   printable, backspace, other byte: one done result; read: one read result
//   newline: up to LINES + 1 results, one per cycle while the output is not stalled
//   clear request: one clear result (slot 0 of one line zeroed per memory write)
// The character memory has a single write port.
// The output register holds one result; the next request is accepted while
// the final result of the previous one still waits. When m_axis_tready stays
// low the sequencer holds before loading the next result; nothing is lost.
// After reset the character memory is zeroed, one byte per cycle, all
// LINES*(COLS+1) bytes (1675 at the default size), before s_axis_tready rises.
// Registers on the APB port may be written at any time the block is idle.
`timescale 1ns / 1ps
module text_console_line_ring #(
    parameter int LINES = 25,
    parameter int COLS  = 66
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_axis_tdata: rx_byte[7:0], query_line[12:8], query_col[19:13], zero pad
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tclr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // s_axis_tuser: req_type[1:0]
    input  logic [tclr_pkg::REQ_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // m_axis_tdata: line_index[4:0], y_pos[16:5], read_char[24:17], zero pad
    output logic [tclr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // m_axis_tuser: kind[1:0]
    output logic [tclr_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tclr_pkg::APB_AW-1:0]        paddr,
    input  logic [tclr_pkg::APB_DW-1:0]        pwdata,
    output logic [tclr_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import tclr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    tclr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tclr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    tclr_dp #(
        .LINES (LINES),
        .COLS  (COLS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg           (cfg),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
